/* rtl/core/bbw_pkg.sv */
// Shared types and constants for the box boundary wrap block.
// No dependencies; used by box_boundary_wrap_top and bbw_div.
`timescale 1ns / 1ps

package bbw_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int LEN_W     = 31;
  localparam int IDX_W     = 3;
  localparam int K_W       = 47;  // 1.5*omega*box_x in Q16.16
  localparam int A_W       = 63;  // shear phase
  localparam int PROD_W    = 79;  // 47 x 32 product
  localparam int DV_W      = 41;  // velocity step, capped at 2^40

  typedef enum logic [1:0] {
    MODE_NONE     = 2'd0,
    MODE_OPEN     = 2'd1,
    MODE_SHEAR    = 2'd2,
    MODE_PERIODIC = 2'd3
  } mode_e;

  localparam logic [IDX_W-1:0] CFG_MODE  = 3'd0;
  localparam logic [IDX_W-1:0] CFG_BOX_X = 3'd1;
  localparam logic [IDX_W-1:0] CFG_BOX_Y = 3'd2;
  localparam logic [IDX_W-1:0] CFG_BOX_Z = 3'd3;
  localparam logic [IDX_W-1:0] CFG_OMEGA = 3'd4;

  localparam logic [LEN_W-1:0] BOX_RESET = 31'd65536;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] pos_x;
    logic signed [WORD_BITS-1:0] pos_y;
    logic signed [WORD_BITS-1:0] pos_z;
    logic signed [WORD_BITS-1:0] vel_y;
    logic [WORD_BITS-1:0]        sim_time;
    logic                        last_in;
  } item_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] new_x;
    logic signed [WORD_BITS-1:0] new_y;
    logic signed [WORD_BITS-1:0] new_z;
    logic signed [WORD_BITS-1:0] new_vy;
    logic                        remove_flag;
    logic                        last_out;
  } res_t;

  // divider request: start pulse and 64-bit dividend select
  typedef struct packed {
    logic start;
    logic wide;
  } div_req_t;

endpackage

/* rtl/core/box_boundary_wrap_top.sv */
// Top level of the box boundary wrap block: config registers, sequencer.
// Depends on bbw_pkg, bbw_mul, bbw_div.
//
//  channel | handshake                  | payload
//  --------+----------------------------+---------------------------------
//  item    | start_i / busy_o           | item_i  (bbw_pkg::item_t)
//  result  | done_o (one-cycle strobe)  | res_o   (bbw_pkg::res_t)
//  config  | cfg_valid_i / cfg_ready_o  | cfg_idx_i, cfg_data_i
//
// One beat at a time. Mode none and open go straight to the result. Periodic:
// each axis is checked and, when it lies outside, wrapped by the 32-step divider.
// Shear adds a chain of multiply steps on the one shared 32x32 unit and a
// 64-bit phase modulo, and y wraps on a 64-bit dividend. Most of the time
// goes to the bit-serial divider. Reset is asynchronous; config
// resets to mode none, box 1.0, omega 0. No clearing pass.
// The receiver cannot stall: done_o shows the result for one cycle.
`timescale 1ns / 1ps

module box_boundary_wrap_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  bbw_pkg::item_t              item_i,
  output logic                        done_o,
  output bbw_pkg::res_t               res_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [bbw_pkg::IDX_W-1:0]   cfg_idx_i,
  input  logic [31:0]                 cfg_data_i
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_WRAP, ST_WWAIT, ST_MP, ST_MK, ST_MA0, ST_MA1, ST_MA2,
    ST_MV1, ST_MV2, ST_MV3, ST_MQ, ST_MQW, ST_MOFF, ST_MOM, ST_MY, ST_FIN
  } state_e;

  // config
  bbw_pkg::mode_e            mode_q;
  logic [bbw_pkg::LEN_W-1:0] box_x_q, box_y_q, box_z_q, omega_q;

  // control
  state_e         state_q, state_d;
  logic           done_q, done_d;
  bbw_pkg::res_t  res_q, res_d;

  // datapath
  logic [1:0]                 ax_q, ax_d;
  logic signed [31:0]         x_q, x_d, z_q, z_d, vy_q, vy_d;
  logic signed [63:0]         y_q, y_d;
  logic [31:0]                t_q, t_d;
  logic                       last_q, last_d;
  logic [31:0]                mag_q, mag_d;
  logic                       cneg_q, cneg_d, side_q, side_d;
  logic [bbw_pkg::K_W-1:0]    k_q, k_d;
  logic [63:0]                acc_q, acc_d;
  logic [bbw_pkg::A_W-1:0]    a_q, a_d;
  logic [bbw_pkg::DV_W-1:0]   dv_q, dv_d;
  logic                       offneg_q, offneg_d;
  logic [bbw_pkg::LEN_W-1:0]  offmag_q, offmag_d;

  // shared units
  logic [31:0]               mul_a, mul_b;
  logic [63:0]               mul_p;
  bbw_pkg::div_req_t         div_req;
  logic [63:0]               div_dvd;
  logic [bbw_pkg::LEN_W-1:0] div_dsr;
  logic                      div_done;
  logic [31:0]               div_quot;
  logic [bbw_pkg::LEN_W-1:0] div_rem;

  // axis selection and wrap arithmetic
  logic signed [63:0]        v64, h64, len64, wres;
  logic [bbw_pkg::LEN_W-1:0] len_sel;
  logic                      v_pos, v_neg;
  logic [63:0]               dvd_w;
  logic [63:0]               k3;
  logic [bbw_pkg::PROD_W-1:0] sum79;
  logic signed [41:0]        vsum;
  logic [bbw_pkg::LEN_W-1:0] s_rem;
  logic                      two_a_le, two_a_lt, twoq_lt, twos_le;
  logic                      shear;

  function automatic logic outside_f(logic signed [63:0] v, logic [bbw_pkg::LEN_W-1:0] len);
    logic signed [63:0] h;
    h = $signed({34'd0, len[bbw_pkg::LEN_W-1:1]});
    return (v > h) || (v < -h);
  endfunction

  bbw_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  bbw_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign shear = (mode_q == bbw_pkg::MODE_SHEAR);

  // axis under work
  always_comb begin
    case (ax_q)
      2'd0:    begin v64 = 64'(x_q); len_sel = box_x_q; end
      2'd1:    begin v64 = y_q;      len_sel = box_y_q; end
      default: begin v64 = 64'(z_q); len_sel = box_z_q; end
    endcase
  end

  assign h64   = $signed({34'd0, len_sel[bbw_pkg::LEN_W-1:1]});
  assign len64 = $signed({33'd0, len_sel});
  assign v_pos = v64 > h64;
  assign v_neg = v64 < -h64;
  assign dvd_w = v_pos ? 64'(v64 - h64 - 64'sd1) : 64'(-v64 - h64 - 64'sd1);
  // wrapped value from the remainder: h+1+r-L above, L-h-1-r below
  assign wres  = side_q ? (h64 + 64'sd1 + $signed({33'd0, div_rem}) - len64)
                        : (len64 - h64 - 64'sd1 - $signed({33'd0, div_rem}));

  // k = round(1.5 * omega * box_x), ties up
  assign k3 = mul_p + {mul_p[62:0], 1'b0} + (64'd1 << bbw_pkg::FRAC_BITS);
  // low partial plus high partial shifted by 32
  assign sum79 = bbw_pkg::PROD_W'(acc_q) + {mul_p[bbw_pkg::PROD_W-33:0], 32'd0};
  assign vsum  = cneg_q ? (42'(vy_q) - $signed({1'b0, dv_q}))
                        : (42'(vy_q) + $signed({1'b0, dv_q}));

  // azimuthal offset selection
  assign s_rem    = (div_rem == '0) ? '0 : box_y_q - div_rem;
  assign two_a_le = {a_q, 1'b0} <= 64'(box_y_q);
  assign two_a_lt = {a_q, 1'b0} <  64'(box_y_q);
  assign twoq_lt  = {div_rem, 1'b0} <  {1'b0, box_y_q};
  assign twos_le  = {s_rem, 1'b0}   <= {1'b0, box_y_q};

  // shared multiplier operands
  always_comb begin
    case (state_q)
      ST_MP:   begin mul_a = 32'(omega_q);       mul_b = 32'(box_x_q); end
      ST_MA0:  begin mul_a = k_q[31:0];          mul_b = t_q;          end
      ST_MA1:  begin mul_a = 32'(k_q[bbw_pkg::K_W-1:32]); mul_b = t_q; end
      ST_MA2:  begin mul_a = k_q[31:0];          mul_b = mag_q;        end
      ST_MV1:  begin mul_a = 32'(k_q[bbw_pkg::K_W-1:32]); mul_b = mag_q; end
      ST_MOM:  begin mul_a = mag_q;              mul_b = 32'(offmag_q); end
      default: begin mul_a = '0;                 mul_b = '0;           end
    endcase
  end

  always_comb begin
    state_d  = state_q;
    done_d   = 1'b0;
    res_d    = res_q;
    ax_d     = ax_q;
    x_d      = x_q;
    y_d      = y_q;
    z_d      = z_q;
    vy_d     = vy_q;
    t_d      = t_q;
    last_d   = last_q;
    mag_d    = mag_q;
    cneg_d   = cneg_q;
    side_d   = side_q;
    k_d      = k_q;
    acc_d    = acc_q;
    a_d      = a_q;
    dv_d     = dv_q;
    offneg_d = offneg_q;
    offmag_d = offmag_q;
    div_req  = '0;
    div_dvd  = dvd_w;
    div_dsr  = len_sel;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          x_d    = item_i.pos_x;
          y_d    = 64'(item_i.pos_y);
          z_d    = item_i.pos_z;
          vy_d   = item_i.vel_y;
          t_d    = item_i.sim_time;
          last_d = item_i.last_in;
          ax_d   = 2'd0;
          mag_d  = '0;
          if (mode_q == bbw_pkg::MODE_SHEAR || mode_q == bbw_pkg::MODE_PERIODIC) begin
            state_d = ST_WRAP;
          end else begin
            state_d = ST_FIN;
          end
        end
      end
      ST_WRAP: begin
        if (len_sel != '0 && (v_pos || v_neg)) begin
          side_d       = v_pos;
          div_req.start = 1'b1;
          div_req.wide  = (ax_q == 2'd1) && shear;
          state_d      = ST_WWAIT;
        end else if (ax_q == 2'd2) begin
          state_d = ST_FIN;
        end else begin
          ax_d = ax_q + 2'd1;
        end
      end
      ST_WWAIT: begin
        if (div_done) begin
          case (ax_q)
            2'd0: begin
              x_d    = wres[31:0];
              mag_d  = div_quot + 32'd1;
              cneg_d = !side_q;
            end
            2'd1:    y_d = wres;
            default: z_d = wres[31:0];
          endcase
          if (ax_q == 2'd0 && shear) begin
            state_d = ST_MP;
          end else if (ax_q == 2'd2) begin
            state_d = ST_FIN;
          end else begin
            ax_d    = ax_q + 2'd1;
            state_d = ST_WRAP;
          end
        end
      end
      ST_MP:  state_d = ST_MK;
      ST_MK: begin
        k_d     = k3[63:bbw_pkg::FRAC_BITS+1];
        state_d = ST_MA0;
      end
      ST_MA0: state_d = ST_MA1;
      ST_MA1: begin
        acc_d   = mul_p;
        state_d = ST_MA2;
      end
      ST_MA2: begin
        a_d     = sum79[bbw_pkg::PROD_W-1:bbw_pkg::FRAC_BITS];
        state_d = ST_MV1;
      end
      ST_MV1: begin
        acc_d   = mul_p;
        state_d = ST_MV2;
      end
      ST_MV2: begin
        dv_d    = (sum79 > (bbw_pkg::PROD_W'(1) << 40)) ? (bbw_pkg::DV_W'(1) << 40)
                                                       : sum79[bbw_pkg::DV_W-1:0];
        state_d = ST_MV3;
      end
      ST_MV3: begin
        if (vsum > 42'sd2147483647) begin
          vy_d = 32'sh7fffffff;
        end else if (vsum < -42'sd2147483648) begin
          vy_d = 32'sh80000000;
        end else begin
          vy_d = vsum[31:0];
        end
        ax_d    = 2'd1;
        state_d = (box_y_q == '0) ? ST_WRAP : ST_MQ;
      end
      ST_MQ: begin
        div_req.start = 1'b1;
        div_req.wide  = 1'b1;
        div_dvd       = {1'b0, a_q};
        div_dsr       = box_y_q;
        state_d       = ST_MQW;
      end
      ST_MQW: begin
        if (div_done) state_d = ST_MOFF;
      end
      ST_MOFF: begin
        if (!cneg_q) begin
          if (two_a_le) begin
            offneg_d = 1'b1;
            offmag_d = box_y_q - a_q[bbw_pkg::LEN_W-1:0];
          end else if (twoq_lt) begin
            offneg_d = 1'b0;
            offmag_d = div_rem;
          end else begin
            offneg_d = 1'b1;
            offmag_d = box_y_q - div_rem;
          end
        end else begin
          if (two_a_lt) begin
            offneg_d = 1'b0;
            offmag_d = box_y_q - a_q[bbw_pkg::LEN_W-1:0];
          end else if (twos_le) begin
            offneg_d = 1'b0;
            offmag_d = s_rem;
          end else begin
            offneg_d = 1'b1;
            offmag_d = box_y_q - s_rem;
          end
        end
        state_d = ST_MOM;
      end
      ST_MOM: state_d = ST_MY;
      ST_MY: begin
        y_d     = offneg_q ? (y_q - $signed(mul_p)) : (y_q + $signed(mul_p));
        ax_d    = 2'd1;
        state_d = ST_WRAP;
      end
      ST_FIN: begin
        res_d.new_x       = x_q;
        res_d.new_y       = y_q[31:0];
        res_d.new_z       = z_q;
        res_d.new_vy      = vy_q;
        res_d.remove_flag = (mode_q == bbw_pkg::MODE_OPEN) &&
                            (outside_f(64'(x_q), box_x_q) || outside_f(y_q, box_y_q) ||
                             outside_f(64'(z_q), box_z_q));
        res_d.last_out    = last_q;
        done_d            = 1'b1;
        state_d           = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state, registered outputs and config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
      res_q   <= '0;
      mode_q  <= bbw_pkg::MODE_NONE;
      box_x_q <= bbw_pkg::BOX_RESET;
      box_y_q <= bbw_pkg::BOX_RESET;
      box_z_q <= bbw_pkg::BOX_RESET;
      omega_q <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      res_q   <= res_d;
      if (cfg_valid_i) begin
        case (cfg_idx_i)
          bbw_pkg::CFG_MODE:  mode_q  <= bbw_pkg::mode_e'(cfg_data_i[1:0]);
          bbw_pkg::CFG_BOX_X: box_x_q <= cfg_data_i[bbw_pkg::LEN_W-1:0];
          bbw_pkg::CFG_BOX_Y: box_y_q <= cfg_data_i[bbw_pkg::LEN_W-1:0];
          bbw_pkg::CFG_BOX_Z: box_z_q <= cfg_data_i[bbw_pkg::LEN_W-1:0];
          bbw_pkg::CFG_OMEGA: omega_q <= cfg_data_i[bbw_pkg::LEN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    ax_q     <= ax_d;
    x_q      <= x_d;
    y_q      <= y_d;
    z_q      <= z_d;
    vy_q     <= vy_d;
    t_q      <= t_d;
    last_q   <= last_d;
    mag_q    <= mag_d;
    cneg_q   <= cneg_d;
    side_q   <= side_d;
    k_q      <= k_d;
    acc_q    <= acc_d;
    a_q      <= a_d;
    dv_q     <= dv_d;
    offneg_q <= offneg_d;
    offmag_q <= offmag_d;
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign done_o      = done_q;
  assign res_o       = res_q;
  assign cfg_ready_o = 1'b1;

endmodule

/* rtl/core/bbw_mul.sv */
// Shared 32x32 unsigned multiplier with registered product.
// No dependencies.
`timescale 1ns / 1ps

module bbw_mul (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] p_o
);

  logic [63:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= 64'(a_i) * 64'(b_i);
  end

  assign p_o = p_q;

endmodule

/* rtl/core/bbw_div.sv */
// Bit-serial restoring divider, 32 or 64 dividend bits by a 31-bit divisor.
// Depends on bbw_pkg (div_req_t, LEN_W).
`timescale 1ns / 1ps

module bbw_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bbw_pkg::div_req_t         req_i,
  input  logic [63:0]               dividend_i,
  input  logic [bbw_pkg::LEN_W-1:0] divisor_i,
  output logic                      done_o,
  output logic [31:0]               quot_o,
  output logic [bbw_pkg::LEN_W-1:0] rem_o
);

  logic                      busy_q;
  logic                      done_q;
  logic [5:0]                cnt_q;
  logic [63:0]               dvd_q;
  logic [bbw_pkg::LEN_W-1:0] rem_q;
  logic [bbw_pkg::LEN_W-1:0] dsr_q;
  logic [31:0]               sh;
  logic                      ge;
  logic [31:0]               diff;

  assign sh   = {rem_q, dvd_q[63]};
  assign ge   = sh >= {1'b0, dsr_q};
  assign diff = sh - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.wide ? 6'd63 : 6'd31;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.wide ? dividend_i : {dividend_i[31:0], 32'd0};
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[62:0], ge};
      rem_q <= ge ? diff[bbw_pkg::LEN_W-1:0] : sh[bbw_pkg::LEN_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = dvd_q[31:0];
  assign rem_o  = rem_q;

endmodule

/* rtl/core/bbw_checker.sv */
// Port-level checks for the box boundary wrap top, attached by bind.
// Depends on box_boundary_wrap_top.
`timescale 1ns / 1ps

module bbw_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic done_o
);

  // an accepted beat makes the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("accept did not raise busy");

  // results only appear when the block has gone idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("result while busy");

  // every end of work delivers a result
  a_fall_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> done_o) else $error("busy fell without result");

  // one result per beat
  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("repeated result strobe");

endmodule

bind box_boundary_wrap_top bbw_checker u_bbw_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .done_o  (done_o)
);
